// File: design/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define PDS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("%m: assertion failed");

// Check that an implication holds on every rising edge outside reset
`define PDS_ASSERT_IMP(lbl, clk, rstn, pre, post) \
	`PDS_ASSERT(lbl, clk, rstn, (pre) |-> (post))

`endif

// File: design/pds_pkg.sv
`timescale 1ns / 1ps

package pds_pkg;

	localparam int OP_W  = 2;
	localparam int POS_W = 16;
	localparam int LEN_W = 13;
	localparam int VAL_W = 12;
	localparam int CNT_W = 13;
	localparam int LIM_W = 13;

	localparam int DEPTH_DEF = 4096;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 13'd4096;

	localparam int Q_DEPTH = 2;
	localparam int Q_PW    = $clog2(Q_DEPTH);

	typedef enum logic [OP_W-1:0] {
		OP_GET  = 2'd0,
		OP_SET  = 2'd1,
		OP_FILL = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		K_NOP   = 2'd0,
		K_READ  = 2'd1,
		K_WRITE = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [POS_W-1:0]  addr;
		logic [CNT_W-1:0]  count;
		logic [VAL_W-1:0]  value;
	} cmd_t;

endpackage

// File: design/pds_in_if.sv
`timescale 1ns / 1ps

interface pds_in_if;
	import pds_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [POS_W-1:0] position;
	logic [LEN_W-1:0] length;
	logic [VAL_W-1:0] value;

	modport source (output valid, op, position, length, value, input ready);
	modport sink (input valid, op, position, length, value, output ready);

endinterface

// File: design/pds_out_if.sv
`timescale 1ns / 1ps

interface pds_out_if;
	import pds_pkg::*;

	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] read_value;
	logic [CNT_W-1:0] written_count;

	modport source (output valid, read_value, written_count, input ready);
	modport sink (input valid, read_value, written_count, output ready);

endinterface

// File: design/packed_dot_line_store.sv
`timescale 1ns / 1ps
// Line store of 12-bit dot words, one word per position, DEPTH entries.
// req carries op, position, length and value; rsp returns read_value and
// written_count, exactly one result word per request word, in order.
// cfg_we/cfg_wdata write the position limit; write it only while idle.
// Positions at or above the smaller of the limit and DEPTH are ignored.
// Get returns the stored word (0 out of range); set writes one word;
// fill writes value over a run clipped at the limit and returns its count.
// A request word passes the classifier into a two-entry queue, then the
// executor runs it against a single-port-write, registered-read RAM.
// The executor takes a queued request only while idle and finishes it before
// taking the next: a get reads the RAM, then loads its word into the output
// register; a set or a fill writes its words in turn through the single RAM
// write port, then loads its count; a request writing nothing loads directly.
// Every result waits until the output register is free to take it.
// Reset clears the queue, the executor and the output register and sets
// the limit to 4096; store contents are undefined until written.
// A stalled rsp holds its word; the queue fills and req.ready drops.

module packed_dot_line_store #(
	parameter int DEPTH = pds_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [pds_pkg::LIM_W-1:0] cfg_wdata,
	pds_in_if.sink                    req,
	pds_out_if.source                 rsp
);
	import pds_pkg::*;

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd_in;
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	pds_front #(
		.DEPTH (DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_in),
		.cmd_ready (cmd_ready)
	);

	pds_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_valid),
		.din    (cmd_in),
		.ready  (cmd_ready),
		.valid  (q_valid),
		.dout   (q_cmd),
		.pop    (q_pop)
	);

	pds_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.rsp       (rsp)
	);

endmodule

// File: design/pds_ram.sv
`timescale 1ns / 1ps

module pds_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/pds_front.sv
`timescale 1ns / 1ps

module pds_front #(
	parameter int DEPTH = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [pds_pkg::LIM_W-1:0] cfg_wdata,
	pds_in_if.sink                    req,
	output logic                      cmd_valid,
	output pds_pkg::cmd_t             cmd,
	input  logic                      cmd_ready
);
	import pds_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = (AW + 1 > POS_W) ? AW + 1 : POS_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [LIM_W-1:0] limit_q;
	logic [CW-1:0]    lim_eff;
	logic [CW-1:0]    pos_ext;
	logic [CW-1:0]    len_ext;
	logic [CW-1:0]    room;
	logic [CNT_W-1:0] fill_cnt;
	logic             in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// clamp the limit at the store depth, then clip the run at it
	always_comb begin
		lim_eff  = (CW'(limit_q) > DEPTH_C) ? DEPTH_C : CW'(limit_q);
		pos_ext  = CW'(req.position);
		len_ext  = CW'(req.length);
		in_range = pos_ext < lim_eff;
		room     = lim_eff - pos_ext;
		fill_cnt = (len_ext > room) ? CNT_W'(room) : req.length;
	end

	always_comb begin
		cmd.kind  = K_NOP;
		cmd.addr  = req.position;
		cmd.count = '0;
		cmd.value = req.value;
		case (req.op)
			OP_GET: begin
				if (in_range) begin
					cmd.kind = K_READ;
				end
			end
			OP_SET: begin
				if (in_range) begin
					cmd.kind  = K_WRITE;
					cmd.count = CNT_W'(1);
				end
			end
			OP_FILL: begin
				if (in_range && fill_cnt != '0) begin
					cmd.kind  = K_WRITE;
					cmd.count = fill_cnt;
				end
			end
			default: begin
				cmd.kind = K_NOP;
			end
		endcase
	end

	assign cmd_valid = req.valid;
	assign req.ready = cmd_ready;

endmodule

// File: design/pds_queue.sv
`timescale 1ns / 1ps

module pds_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pds_pkg::cmd_t din,
	output logic          ready,
	output logic          valid,
	output pds_pkg::cmd_t dout,
	input  logic          pop
);
	import pds_pkg::*;

	cmd_t            entry [Q_DEPTH];
	logic [Q_PW-1:0] wr_ptr_q;
	logic [Q_PW-1:0] rd_ptr_q;
	logic [Q_PW:0]   fill_q;
	logic            do_push;
	logic            do_pop;

	assign ready   = fill_q != (Q_PW + 1)'(Q_DEPTH);
	assign valid   = fill_q != '0;
	assign dout    = entry[rd_ptr_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (Q_PW + 1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (Q_PW + 1)'(1);
			end
		end
	end

endmodule

// File: design/pds_back.sv
`timescale 1ns / 1ps

module pds_back #(
	parameter int DEPTH = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  pds_pkg::cmd_t cmd,
	output logic          cmd_pop,
	pds_out_if.source     rsp
);
	import pds_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_FILL
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    addr_q;
	logic [CNT_W-1:0] remain_q;
	logic [CNT_W-1:0] total_q;
	logic [VAL_W-1:0] value_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] out_read_q;
	logic [CNT_W-1:0] out_count_q;

	logic             out_free;
	logic             out_load;
	logic             fill_go;
	logic             last_word;
	logic             ram_re;
	logic [VAL_W-1:0] ram_rdata;

	assign out_free  = !out_valid_q || rsp.ready;
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid && (cmd.kind != K_NOP || out_free);
	assign ram_re    = cmd_pop && cmd.kind == K_READ;
	assign last_word = remain_q == CNT_W'(1);
	// hold the last word until the result has somewhere to go
	assign fill_go   = (state_q == ST_FILL) && (!last_word || out_free);
	assign out_load  = ((state_q == ST_IDLE) && cmd_pop && !(cmd.kind inside {K_READ, K_WRITE}))
		|| ((state_q == ST_READ) && out_free) || (fill_go && last_word);

	pds_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (fill_go),
		.waddr (addr_q),
		.wdata (value_q),
		.re    (ram_re),
		.raddr (cmd.addr[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			addr_q      <= '0;
			remain_q    <= '0;
			total_q     <= '0;
			value_q     <= '0;
			out_valid_q <= 1'b0;
			out_read_q  <= '0;
			out_count_q <= '0;
		end else begin
			if (out_valid_q && rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.kind)
							K_READ: begin
								state_q <= ST_READ;
							end
							K_WRITE: begin
								addr_q   <= cmd.addr[AW-1:0];
								remain_q <= cmd.count;
								total_q  <= cmd.count;
								value_q  <= cmd.value;
								state_q  <= ST_FILL;
							end
							default: begin
								out_valid_q <= 1'b1;
								out_read_q  <= '0;
								out_count_q <= '0;
							end
						endcase
					end
				end
				ST_READ: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_read_q  <= ram_rdata;
						out_count_q <= '0;
						state_q     <= ST_IDLE;
					end
				end
				ST_FILL: begin
					if (fill_go) begin
						addr_q   <= addr_q + AW'(1);
						remain_q <= remain_q - CNT_W'(1);
						if (last_word) begin
							out_valid_q <= 1'b1;
							out_read_q  <= '0;
							out_count_q <= total_q;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.read_value    = out_read_q;
	assign rsp.written_count = out_count_q;

endmodule

// File: design/pds_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pds_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_we,
	input logic [pds_pkg::LIM_W-1:0] cfg_wdata,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [pds_pkg::VAL_W-1:0] rsp_read_value,
	input logic [pds_pkg::CNT_W-1:0] rsp_written_count
);
	import pds_pkg::*;

	logic [2:0]       pending_q;
	logic [LIM_W-1:0] lim_q;
	logic             req_acc;
	logic             rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			lim_q     <= LIMIT_RESET;
		end else begin
			if (req_acc && !rsp_acc) begin
				pending_q <= pending_q + 3'd1;
			end else if (rsp_acc && !req_acc) begin
				pending_q <= pending_q - 3'd1;
			end
			if (cfg_we) begin
				lim_q <= cfg_wdata;
			end
		end
	end

	`PDS_ASSERT_IMP(a_no_orphan_result, clk, arst_n, rsp_valid, pending_q != 3'd0)
	`PDS_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid &&
		$stable(rsp_read_value) && $stable(rsp_written_count))
	`PDS_ASSERT_IMP(a_count_in_limit, clk, arst_n, rsp_valid, rsp_written_count <= lim_q)
	`PDS_ASSERT_IMP(a_read_no_count, clk, arst_n, rsp_valid && rsp_read_value != '0,
		rsp_written_count == '0)

endmodule

bind packed_dot_line_store pds_checker u_pds_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cfg_we            (cfg_we),
	.cfg_wdata         (cfg_wdata),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_read_value    (rsp.read_value),
	.rsp_written_count (rsp.written_count)
);
